// File: sv/assert_macros.svh
// assertion macros shared by the planner rtl
// unless ASSERT_OFF, each macro is a concurrent assertion on clk, reset rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define TAPP_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define TAPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TAPP_ASSERT_ALWAYS(lbl, expr)
`define TAPP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: sv/tapp_pkg.sv
// types, constants and helper functions of the trapezoid profile planner
// no dependencies
`timescale 1ns / 1ps
package tapp_pkg;

  localparam int MOTORS    = 2;
  localparam int TBL_DEPTH = 8;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int ENT_W     = 128;

  // change table slots
  localparam logic [TBL_AW-1:0] E_FIRST_UP   = 3'd0;
  localparam logic [TBL_AW-1:0] E_K1_UP      = 3'd1;
  localparam logic [TBL_AW-1:0] E_LAST_UP    = 3'd2;
  localparam logic [TBL_AW-1:0] E_TOP        = 3'd3;
  localparam logic [TBL_AW-1:0] E_FIRST_DOWN = 3'd4;
  localparam logic [TBL_AW-1:0] E_K1_DOWN    = 3'd5;
  localparam logic [TBL_AW-1:0] E_LAST_DOWN  = 3'd6;
  localparam logic [TBL_AW-1:0] E_END        = 3'd7;
  localparam logic [TBL_AW-1:0] E_LAST_WALK  = 3'd6;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_ISSUE, S_WAIT, S_NEXT, S_FIX1, S_FIX2, S_FIX3, S_WRITE,
    S_RD0, S_RD1, S_WALK, S_EMA, S_EMB, S_ADV, S_RDW, S_FINAL
  } ctrl_state_t;

  typedef enum logic [3:0] {
    ST_N, ST_NM1A, ST_NN, ST_D, ST_X, ST_ROOT, ST_RNN, ST_RCHK, ST_L, ST_SNN,
    ST_S1, ST_S2, ST_S3, ST_DA0, ST_DSUB
  } step_t;

  typedef enum logic [1:0] {AR_MUL, AR_DIV, AR_ROOT} arith_op_t;
  typedef enum logic [1:0] {FX_NONE, FX_K1, FX_K1SET, FX_TOP} fix_t;
  typedef enum logic [1:0] {EM_A, EM_B, EM_FINAL} emit_t;

  typedef struct packed {
    logic              load;
    logic              start;
    step_t             step;
    logic              apply;
    fix_t              fix;
    logic              we;
    logic [TBL_AW-1:0] waddr;
    logic [TBL_AW-1:0] raddr;
    logic              cur_load;
    logic              da_add;
    logic              set_t;
    logic              step_b;
    logic              emit;
    emit_t             emit_kind;
  } cmd_t;

  typedef struct packed {
    logic motor_ok;
    logic arith_done;
    logic d_neg;
    logic pos_ne;
    logic t_ne;
    logic need_a;
    logic need_b;
    logic out_free;
  } sts_t;

  function automatic arith_op_t step_op(input step_t s);
    arith_op_t op;
    op = AR_MUL;
    if (s inside {ST_N, ST_X, ST_L, ST_DA0}) op = AR_DIV;
    if (s == ST_ROOT) op = AR_ROOT;
    return op;
  endfunction

  function automatic step_t next_step(input step_t s, input logic d_neg);
    step_t r;
    case (s)
      ST_N:    r = ST_NM1A;
      ST_NM1A: r = ST_NN;
      ST_NN:   r = ST_D;
      ST_D:    r = d_neg ? ST_X : ST_L;
      ST_X:    r = ST_ROOT;
      ST_ROOT: r = ST_RNN;
      ST_RNN:  r = ST_RCHK;
      ST_RCHK: r = ST_SNN;
      ST_L:    r = ST_SNN;
      ST_SNN:  r = ST_S1;
      ST_S1:   r = ST_S2;
      ST_S2:   r = ST_S3;
      ST_S3:   r = ST_DA0;
      ST_DA0:  r = ST_DSUB;
      default: r = ST_DSUB;
    endcase
    return r;
  endfunction

endpackage

// File: sv/tapp_if.sv
// stream interfaces of the planner: move command in, acceleration event out
// depends on nothing
`timescale 1ns / 1ps
interface tapp_cmd_if;
  logic               valid;
  logic               ready;
  logic               motor_index;
  logic        [31:0] move_start;
  logic        [15:0] accel_max;
  logic        [15:0] velocity_max;
  logic signed [31:0] distance;
  modport source (output valid, motor_index, move_start, accel_max, velocity_max,
                  distance, input ready);
  modport sink (input valid, motor_index, move_start, accel_max, velocity_max,
                distance, output ready);
endinterface

interface tapp_evt_if;
  logic               valid;
  logic               ready;
  logic               motor_out;
  logic        [31:0] event_time;
  logic signed [31:0] accel_value;
  logic               last;
  modport source (output valid, motor_out, event_time, accel_value, last, input ready);
  modport sink (input valid, motor_out, event_time, accel_value, last, output ready);
endinterface

// File: sv/tapp_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module tapp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: sv/tapp_arith.sv
// shared multi-cycle arithmetic unit: 64-bit wrapping multiply, divide, square root
// uses tapp_pkg
`timescale 1ns / 1ps
module tapp_arith (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  tapp_pkg::arith_op_t op,
  input  logic [63:0]        opa,
  input  logic [63:0]        opb,
  output logic               done,
  output logic [63:0]        res
);
  import tapp_pkg::*;

  localparam logic [6:0] MUL_LAST  = 7'd3;
  localparam logic [6:0] DIV_LAST  = 7'd63;
  localparam logic [6:0] ROOT_LAST = 7'd15;

  logic        busy_r, busy_nxt, done_r, done_nxt;
  arith_op_t   op_r, op_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] x_r, x_nxt, y_r, y_nxt, acc_r, acc_nxt, prod_r, prod_nxt;
  logic [63:0] rem_r, rem_nxt;

  logic [31:0] m_a, m_b;
  logic [63:0] mprod;
  logic [64:0] rem_sh;
  logic        qbit;
  logic [3:0]  bp;
  logic [15:0] trial;
  logic [31:0] sq;
  logic        last_step;

  // partial products of the low 64 bits
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    begin m_a = x_r[31:0];  m_b = y_r[31:0];  end
      2'd1:    begin m_a = x_r[31:0];  m_b = y_r[63:32]; end
      default: begin m_a = x_r[63:32]; m_b = y_r[31:0];  end
    endcase
  end
  assign mprod = 64'(m_a) * 64'(m_b);

  assign rem_sh = {rem_r, x_r[63]};
  assign qbit   = rem_sh >= {1'b0, y_r};
  assign bp     = 4'(ROOT_LAST) - cnt_r[3:0];
  assign trial  = acc_r[15:0] | (16'd1 << bp);
  assign sq     = 32'(trial) * 32'(trial);

  always_comb begin
    case (op_r)
      AR_MUL:  last_step = cnt_r == MUL_LAST;
      AR_DIV:  last_step = cnt_r == DIV_LAST;
      default: last_step = cnt_r == ROOT_LAST;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      op_nxt   = op;
      cnt_nxt  = '0;
      x_nxt    = opa;
      y_nxt    = opb;
      acc_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 7'd1;
      case (op_r)
        AR_MUL: begin
          prod_nxt = mprod;
          if (cnt_r == 7'd1) acc_nxt = prod_r;
          else if (cnt_r != 7'd0) acc_nxt = acc_r + {prod_r[31:0], 32'd0};
        end
        AR_DIV: begin
          rem_nxt = qbit ? 64'(rem_sh - {1'b0, y_r}) : rem_sh[63:0];
          x_nxt   = {x_r[62:0], qbit};
        end
        default: begin
          if ({32'd0, sq} <= x_r) acc_nxt = {48'd0, trial};
        end
      endcase
      if (last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= AR_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign res  = (op_r == AR_DIV) ? ((y_r == 64'd0) ? 64'd0 : x_r) : acc_r;
endmodule

// File: sv/tapp_ctrl.sv
// controller of the planner: sequences planning steps, table fill and table walk
// uses tapp_pkg, drives tapp_dp through cmd_t and reads sts_t
`timescale 1ns / 1ps
module tapp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tapp_pkg::sts_t sts,
  output tapp_pkg::cmd_t cmd
);
  import tapp_pkg::*;

  ctrl_state_t       state_r, state_nxt;
  step_t             step_r, step_nxt;
  logic [TBL_AW-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_LOAD;
      S_LOAD: begin
        step_nxt  = ST_N;
        state_nxt = sts.motor_ok ? S_ISSUE : S_IDLE;
      end
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT:  if (sts.arith_done) state_nxt = S_NEXT;
      S_NEXT: begin
        if (step_r == ST_DSUB) begin
          state_nxt = S_FIX1;
        end else begin
          step_nxt  = next_step(step_r, sts.d_neg);
          state_nxt = S_ISSUE;
        end
      end
      S_FIX1:  state_nxt = S_FIX2;
      S_FIX2:  state_nxt = S_FIX3;
      S_FIX3: begin
        idx_nxt   = '0;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == E_END) state_nxt = S_RD0;
      end
      S_RD0:   state_nxt = S_RD1;
      S_RD1:   state_nxt = S_WALK;
      S_WALK:  state_nxt = sts.pos_ne ? S_EMA : S_ADV;
      S_EMA:   if (!(sts.t_ne && sts.need_a) || sts.out_free) state_nxt = S_EMB;
      S_EMB:   if (!sts.need_b || sts.out_free) state_nxt = S_ADV;
      S_ADV: begin
        if (idx_r == E_LAST_WALK) begin
          state_nxt = S_FINAL;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RDW;
        end
      end
      S_RDW:   state_nxt = S_WALK;
      S_FINAL: if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.step      = step_r;
    cmd.fix       = FX_NONE;
    cmd.emit_kind = EM_A;
    cmd.waddr     = idx_r;
    cmd.raddr     = (state_r == S_RD0) ? '0 : idx_r + 1'b1;
    in_ready      = state_r == S_IDLE;
    case (state_r)
      S_IDLE:  cmd.load = in_valid;
      S_ISSUE: cmd.start = 1'b1;
      S_WAIT:  cmd.apply = sts.arith_done;
      S_FIX1:  cmd.fix = FX_K1;
      S_FIX2:  cmd.fix = FX_K1SET;
      S_FIX3:  cmd.fix = FX_TOP;
      S_WRITE: cmd.we = 1'b1;
      S_RD1:   cmd.cur_load = 1'b1;
      S_WALK:  cmd.da_add = 1'b1;
      S_EMA: begin
        if (sts.t_ne) begin
          if (!sts.need_a) begin
            cmd.set_t = 1'b1;
          end else if (sts.out_free) begin
            cmd.set_t = 1'b1;
            cmd.emit  = 1'b1;
          end
        end
      end
      S_EMB: begin
        cmd.emit_kind = EM_B;
        if (!sts.need_b) begin
          cmd.step_b = 1'b1;
        end else if (sts.out_free) begin
          cmd.step_b = 1'b1;
          cmd.emit   = 1'b1;
        end
      end
      S_ADV:   cmd.cur_load = 1'b1;
      S_FINAL: begin
        cmd.emit_kind = EM_FINAL;
        cmd.emit      = sts.out_free;
      end
      default: cmd.load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= ST_N;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      idx_r   <= idx_nxt;
    end
  end
endmodule

// File: sv/tapp_dp.sv
// datapath of the planner: profile registers, change table, walk and event register
// uses tapp_pkg, tapp_arith and tapp_ram
`timescale 1ns / 1ps
module tapp_dp #(
  parameter int NUM_MOTORS = tapp_pkg::MOTORS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tapp_pkg::cmd_t     cmd,
  output tapp_pkg::sts_t     sts,
  input  logic               in_motor_index,
  input  logic        [31:0] in_move_start,
  input  logic        [15:0] in_accel_max,
  input  logic        [15:0] in_velocity_max,
  input  logic signed [31:0] in_distance,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_motor_out,
  output logic        [31:0] out_event_time,
  output logic signed [31:0] out_accel_value,
  output logic               out_last
);
  import tapp_pkg::*;

  logic        motor_r, back_r;
  logic [31:0] start_r;
  logic [15:0] a_r, v_r;
  logic [30:0] sres_r;
  logic [63:0] n_r, l_r, adj_r, d_r, s_r, ds_r, span_r, da0_r, tmp_r, k1_r;
  logic [63:0] dlu_r, dfd_r, ptop_r;
  logic        dtop_r, k1set_r, dsnz_r;
  logic [63:0] t_r, da_r, prev_r, cur_diff_r, cur_pos_r;
  logic        pv_r;
  logic        ov_r, om_r, ol_r;
  logic [31:0] ot_r, oa_r;

  logic [63:0] a64, v64, sres64, opa, opb, ares, rd_diff, rd_pos;
  logic [63:0] ramp_t, acc_a, acc_b, acc_sel, ds_k1;
  logic        adone;
  logic [31:0] mag;
  logic [ENT_W-1:0] wdata, rdata;

  assign a64    = {48'd0, a_r};
  assign v64    = {48'd0, v_r};
  assign sres64 = {33'd0, sres_r};
  assign mag    = in_distance[31] ? 32'(-in_distance) : in_distance;

  always_comb begin
    case (cmd.step)
      ST_N:    begin opa = v64 + a64 - 64'd1; opb = a64;   end
      ST_NM1A: begin opa = n_r - 64'd1;       opb = a64;   end
      ST_D:    begin opa = a64;               opb = tmp_r - 64'd1; end
      ST_S1:   begin opa = a64;               opb = tmp_r - 64'd1; end
      ST_X:    begin opa = sres64;            opb = a64;   end
      ST_ROOT: begin opa = tmp_r;             opb = '0;    end
      ST_RCHK: begin opa = tmp_r;             opb = a64;   end
      ST_L:    begin opa = d_r + v64 - 64'd1; opb = v64;   end
      ST_S2:   begin opa = a64;               opb = n_r - 64'd1; end
      ST_S3:   begin opa = l_r;               opb = tmp_r; end
      ST_DA0:  begin opa = ds_r;              opb = span_r; end
      ST_DSUB: begin opa = da0_r;             opb = span_r; end
      default: begin opa = n_r;               opb = n_r;   end
    endcase
  end

  tapp_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .op    (step_op(cmd.step)),
    .opa   (opa),
    .opb   (opb),
    .done  (adone),
    .res   (ares)
  );

  // table entry being written
  always_comb begin
    case (cmd.waddr)
      E_FIRST_UP:   wdata = {64'd0 - da0_r, 64'd0};
      E_K1_UP:      wdata = k1set_r ? {64'hFFFF_FFFF_FFFF_FFFF, k1_r} : {64'd0, 64'd0};
      E_LAST_UP:    wdata = {dlu_r, n_r - 64'd1};
      E_TOP:        wdata = {63'd0, dtop_r, ptop_r};
      E_FIRST_DOWN: wdata = {dfd_r, n_r + l_r};
      E_K1_DOWN:    wdata = k1set_r ? {64'd1, span_r - k1_r} : {64'd0, span_r};
      E_LAST_DOWN:  wdata = {da0_r, span_r};
      default:      wdata = {64'd0, 64'h0000_0000_FFFF_FFFF};
    endcase
  end

  tapp_ram #(.WIDTH(ENT_W), .DEPTH(TBL_DEPTH)) u_table (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (cmd.waddr),
    .wdata (wdata),
    .raddr (cmd.raddr),
    .rdata (rdata)
  );
  assign rd_diff = rdata[ENT_W-1:64];
  assign rd_pos  = rdata[63:0];

  // ramp acceleration at the current time
  always_comb begin
    if (t_r < n_r) ramp_t = a64;
    else if (t_r >= n_r + l_r) ramp_t = 64'd0 - a64;
    else ramp_t = 64'd0;
  end
  assign acc_a = back_r ? 64'd0 - ramp_t : ramp_t;
  assign acc_b = back_r ? 64'd0 - (da_r + ramp_t) : da_r + ramp_t;
  assign acc_sel = (cmd.emit_kind == EM_B) ? acc_b : acc_a;
  assign ds_k1 = ds_r - (64'd2 * (n_r - k1_r) + l_r - 64'd1);

  assign sts.motor_ok   = {31'd0, motor_r} < 32'(NUM_MOTORS);
  assign sts.arith_done = adone;
  assign sts.d_neg      = d_r[63];
  assign sts.pos_ne     = cur_pos_r != rd_pos;
  assign sts.t_ne       = t_r != cur_pos_r;
  assign sts.need_a     = !pv_r || prev_r != acc_a;
  assign sts.need_b     = !pv_r || prev_r != acc_b;
  assign sts.out_free   = !ov_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      motor_r <= in_motor_index;
      start_r <= in_move_start;
      a_r     <= (in_accel_max == 16'd0) ? 16'd1 : in_accel_max;
      v_r     <= (in_velocity_max == 16'd0) ? 16'd1 : in_velocity_max;
      back_r  <= in_distance[31];
      sres_r  <= mag[31:1];
      t_r     <= '0;
      da_r    <= '0;
    end
    if (cmd.apply) begin
      case (cmd.step)
        ST_N:    n_r <= ares;
        ST_NM1A: adj_r <= v64 - ares;
        ST_D:    d_r <= sres64 - ares - adj_r;
        ST_ROOT: n_r <= ares;
        ST_RCHK: begin
          if (ares < sres64) n_r <= n_r + 64'd1;
          adj_r <= a64;
          l_r   <= '0;
          dlu_r <= '0;
          dfd_r <= '0;
        end
        ST_L: begin
          l_r   <= ares;
          dlu_r <= adj_r - a64;
          dfd_r <= a64 - adj_r;
        end
        ST_S1:   s_r <= ares + adj_r;
        ST_S2:   tmp_r <= ares + adj_r;
        ST_S3: begin
          ds_r   <= s_r + ares - sres64;
          span_r <= 64'd2 * n_r + l_r - 64'd1;
        end
        ST_DA0:  da0_r <= ares;
        ST_DSUB: ds_r <= ds_r - ares;
        default: tmp_r <= ares;
      endcase
    end
    case (cmd.fix)
      FX_K1: begin
        dsnz_r  <= ds_r != 64'd0;
        k1_r    <= (64'd2 * n_r + l_r - ds_r) >> 1;
        k1set_r <= 1'b0;
        dtop_r  <= 1'b0;
        ptop_r  <= n_r;
      end
      FX_K1SET: begin
        if (dsnz_r && k1_r < n_r) begin
          k1set_r <= 1'b1;
          ds_r    <= ds_k1;
        end
      end
      FX_TOP: begin
        if (dsnz_r && ds_r != 64'd0) begin
          dlu_r  <= dlu_r - 64'd1;
          dtop_r <= 1'b1;
          ptop_r <= n_r + ds_r - 64'd1;
        end
      end
      default: ;
    endcase
    if (cmd.cur_load) begin
      cur_diff_r <= rd_diff;
      cur_pos_r  <= rd_pos;
    end
    if (cmd.da_add) da_r <= da_r + cur_diff_r;
    if (cmd.set_t) t_r <= cur_pos_r;
    if (cmd.step_b) begin
      t_r  <= t_r + 64'd1;
      da_r <= '0;
    end
    if (cmd.emit) begin
      om_r   <= motor_r;
      ot_r   <= start_r + t_r[31:0];
      oa_r   <= (cmd.emit_kind == EM_FINAL) ? 32'd0 : acc_sel[31:0];
      ol_r   <= cmd.emit_kind == EM_FINAL;
      prev_r <= acc_sel;
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      if (cmd.emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (cmd.load) pv_r <= 1'b0;
      else if (cmd.emit) pv_r <= 1'b1;
    end
  end

  assign out_valid       = ov_r;
  assign out_motor_out   = om_r;
  assign out_event_time  = ot_r;
  assign out_accel_value = oa_r;
  assign out_last        = ol_r;
endmodule

// File: sv/trapezoid_accel_profile_planner_unit.sv
// top level of the trapezoid acceleration profile planner
// uses tapp_pkg, tapp_if, tapp_ctrl, tapp_dp (with tapp_arith, tapp_ram), assert_macros.svh
`timescale 1ns / 1ps
// One move command in, a list of timed acceleration changes out. Each command
// is planned into a trapezoid (ramp n, cruise l, ramp down) or, for short moves,
// a triangle whose ramp comes from an integer square root; rounding corrections
// go into an eight-entry change table that is then walked to produce events.
// Changes are negated for backward moves and dropped when equal to the last
// emitted value; the final event has acceleration 0, last set, and its time is
// the new period. A command for a motor index not below NUM_MOTORS yields nothing.
// Commands are taken one at a time, and each one can be held up by stalls of
// the event sink. The run time is set by the shared arithmetic unit, mainly
// its bit-per-cycle 64-bit divider (three divisions per move), plus the
// multiplies, the square root, the table fill and the walk of the table
// entries. The last event may still wait in the output register while the
// next command is taken.
module trapezoid_accel_profile_planner_unit #(
  parameter int NUM_MOTORS = tapp_pkg::MOTORS
) (
  input logic       clk,
  input logic       rst_n,
  tapp_cmd_if.sink  in_ch,
  tapp_evt_if.source out_ch
);
  import tapp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing of planning, table fill and walk
  tapp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic, change table and event output register
  tapp_dp #(.NUM_MOTORS(NUM_MOTORS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_motor_index  (in_ch.motor_index),
    .in_move_start   (in_ch.move_start),
    .in_accel_max    (in_ch.accel_max),
    .in_velocity_max (in_ch.velocity_max),
    .in_distance     (in_ch.distance),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_motor_out   (out_ch.motor_out),
    .out_event_time  (out_ch.event_time),
    .out_accel_value (out_ch.accel_value),
    .out_last        (out_ch.last)
  );

`include "assert_macros.svh"

  // results are written back only when the arithmetic unit has finished
  `TAPP_ASSERT_ALWAYS(apply_needs_done, !cmd.apply || sts.arith_done)
  // an event is loaded only into a free output register
  `TAPP_ASSERT_ALWAYS(emit_when_free, !cmd.emit || sts.out_free)
  // a transfer on the command side makes the block busy
  `TAPP_ASSERT_NEXT(busy_after_transfer, in_ch.valid && in_ch.ready, !in_ch.ready)
  // an event is never loaded in the same cycle a command transfer happens
  `TAPP_ASSERT_ALWAYS(no_emit_while_idle, !(cmd.emit && in_ch.ready))
endmodule
